// ===== design/bsmv_pkg.sv =====
// Shared constants and types for the block-sparse 3x3 matrix-vector unit.
// No dependencies; every other design file refers to it by scoped names.
package bsmv_pkg;

  localparam int COL_W             = 10;  // block column / vector index field
  localparam int ROW_W             = 10;  // emitted row counter
  localparam int NUM_ROWS          = 3;
  localparam int NUM_COEF          = 9;
  localparam int DEF_VECTOR_BLOCKS = 1024;
  localparam int DEF_VALUE_WIDTH   = 32;
  localparam int QUEUE_DEPTH       = 4;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_PRESET = 2'd1,
    FUNC_MAC    = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  // control part of a queue entry
  typedef struct packed {
    func_e op;
    logic  row_end;
  } op_ctrl_t;

endpackage

// ===== design/bsmv_front.sv =====
// Front end: accepts input beats, drops no-ops, reduces the column to a store
// index and hands the classified item to the queue. Uses bsmv_pkg.
module bsmv_front #(
  parameter int VECTOR_BLOCKS = bsmv_pkg::DEF_VECTOR_BLOCKS,
  parameter int VALUE_WIDTH   = bsmv_pkg::DEF_VALUE_WIDTH,
  localparam int AW           = $clog2(VECTOR_BLOCKS),
  localparam int COEFS_W      = bsmv_pkg::NUM_COEF * VALUE_WIDTH
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [bsmv_pkg::COL_W-1:0]  column_i,
  input  logic [COEFS_W-1:0]          coefs_i,
  input  logic                        row_end_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output bsmv_pkg::op_ctrl_t          ent_ctrl_o,
  output logic [AW-1:0]               ent_idx_o,
  output logic [COEFS_W-1:0]          ent_coefs_o
);

  localparam int WIDE_W = bsmv_pkg::COL_W + 18;
  localparam int SHIFT  = bsmv_pkg::COL_W + AW;
  localparam int MUL_W  = bsmv_pkg::COL_W + SHIFT;
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(VECTOR_BLOCKS) - 64'd1) / 64'(VECTOR_BLOCKS);

  bsmv_pkg::func_e            op;
  logic [bsmv_pkg::COL_W-1:0] quo;
  logic [WIDE_W-1:0]          rem;

  assign op         = bsmv_pkg::func_e'(func_i);
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && (op != bsmv_pkg::FUNC_NOP);

  // column modulo store depth: the rounded-up reciprocal gives the exact quotient
  // for every column value, then subtract quotient times depth
  assign quo = bsmv_pkg::COL_W'((MUL_W'(column_i) * MUL_W'(RECIP)) >> SHIFT);
  assign rem = WIDE_W'(column_i) - WIDE_W'(quo) * WIDE_W'(VECTOR_BLOCKS);

  assign ent_idx_o          = AW'(rem);
  assign ent_ctrl_o.op      = op;
  // a load never ends a row
  assign ent_ctrl_o.row_end = row_end_i && (op != bsmv_pkg::FUNC_LOAD);
  assign ent_coefs_o        = coefs_i;

endmodule

// ===== design/bsmv_queue.sv =====
// Short FIFO between front and back so that each side stalls on its own.
// Generic width; depth default from bsmv_pkg.
module bsmv_queue #(
  parameter int DEPTH = bsmv_pkg::QUEUE_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
`endif

endmodule

// ===== design/bsmv_back.sv =====
// Back end: vector store, nine multipliers, row accumulators and the
// saturating output register. Pops classified items from bsmv_queue; uses bsmv_pkg.
module bsmv_back #(
  parameter int VECTOR_BLOCKS = bsmv_pkg::DEF_VECTOR_BLOCKS,
  parameter int VALUE_WIDTH   = bsmv_pkg::DEF_VALUE_WIDTH,
  localparam int AW           = $clog2(VECTOR_BLOCKS),
  localparam int COEFS_W      = bsmv_pkg::NUM_COEF * VALUE_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  bsmv_pkg::op_ctrl_t          q_ctrl_i,
  input  logic [AW-1:0]               q_idx_i,
  input  logic [COEFS_W-1:0]          q_coefs_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [VALUE_WIDTH-1:0]      sum0_o,
  output logic [VALUE_WIDTH-1:0]      sum1_o,
  output logic [VALUE_WIDTH-1:0]      sum2_o,
  output logic [bsmv_pkg::ROW_W-1:0]  row_number_o,
  output logic                        saturated_o
);

  localparam int VW     = VALUE_WIDTH;
  localparam int FRAC   = VW / 2;
  localparam int PROD_W = 2 * VW;
  localparam int ACC_W  = 2 * VW + 8;
  localparam int SH_W   = ACC_W - FRAC;
  localparam int NR     = bsmv_pkg::NUM_ROWS;
  localparam int NC     = bsmv_pkg::NUM_COEF;
  localparam int ROW_W  = bsmv_pkg::ROW_W;

  logic adv;

  // vector store and stage 1
  logic [NR*VW-1:0]     mem [VECTOR_BLOCKS];
  logic [NR*VW-1:0]     rd_q;
  logic                 s1_vld_q, s1_preset_q, s1_row_end_q;
  logic [COEFS_W-1:0]   s1_coef_q;

  // stage 2: products
  logic signed [PROD_W-1:0] prod     [NC];
  logic signed [PROD_W-1:0] s2_prod_q[NC];
  logic                     s2_vld_q, s2_preset_q, s2_row_end_q;

  // stage 3: per-row block sums, accumulators
  logic [ACC_W-1:0] sum      [NR];
  logic [ACC_W-1:0] s3_sum_q [NR];
  logic             s3_vld_q, s3_preset_q, s3_row_end_q;
  logic [ACC_W-1:0] acc_q [NR];
  logic [ACC_W-1:0] acc_d [NR];
  logic [ACC_W-1:0] acc_new [NR];
  logic [ROW_W-1:0] row_cnt_q, row_cnt_d;

  // stage 4: emitted row
  logic             s4_vld_q;
  logic [ACC_W-1:0] s4_acc_q [NR];
  logic [ROW_W-1:0] s4_row_q;

  // output register
  logic             out_vld_q;
  logic [VW-1:0]    fin_val [NR];
  logic [NR-1:0]    fin_sat;
  logic [VW-1:0]    out_sum_q [NR];
  logic [ROW_W-1:0] out_row_q;
  logic             out_sat_q;

  // the whole back pipeline holds while a result waits on a stalled sink
  assign adv     = !out_vld_q || !out_stall_i;
  assign q_pop_o = adv && !q_empty_i;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (q_ctrl_i.op == bsmv_pkg::FUNC_LOAD) begin
        mem[q_idx_i] <= q_coefs_i[NR*VW-1:0];
      end
      rd_q <= mem[q_idx_i];
    end
  end

  // multiply one block by the stored x block; a preset passes z << FRAC instead
  always_comb begin
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NR; c++) begin
        if (s1_preset_q) begin
          prod[r*NR+c] = '0;
        end else begin
          prod[r*NR+c] = $signed(s1_coef_q[(r*NR+c)*VW +: VW]) * $signed(rd_q[c*VW +: VW]);
        end
      end
      if (s1_preset_q) begin
        prod[r*NR] = {{(PROD_W-VW-FRAC){s1_coef_q[r*VW+VW-1]}},
                      s1_coef_q[r*VW +: VW], {FRAC{1'b0}}};
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      sum[r] = '0;
      for (int c = 0; c < NR; c++) begin
        sum[r] = sum[r] + {{(ACC_W-PROD_W){s2_prod_q[r*NR+c][PROD_W-1]}}, s2_prod_q[r*NR+c]};
      end
    end
  end

  always_comb begin
    row_cnt_d = row_cnt_q;
    for (int r = 0; r < NR; r++) begin
      acc_new[r] = s3_preset_q ? s3_sum_q[r] : acc_q[r] + s3_sum_q[r];
      acc_d[r]   = acc_q[r];
      if (s3_vld_q) begin
        acc_d[r] = s3_row_end_q ? '0 : acc_new[r];
      end
    end
    if (s3_vld_q && s3_row_end_q) begin
      row_cnt_d = row_cnt_q + 1'b1;
    end
  end

  // drop FRAC bits (floor), then clip to the value range
  always_comb begin
    for (int r = 0; r < NR; r++) begin
      logic [SH_W-1:0]    sh;
      logic [SH_W-VW:0]   upper;
      sh    = s4_acc_q[r][ACC_W-1:FRAC];
      upper = sh[SH_W-1:VW-1];
      if ((&upper) || !(|upper)) begin
        fin_val[r] = sh[VW-1:0];
        fin_sat[r] = 1'b0;
      end else begin
        fin_val[r] = s4_acc_q[r][ACC_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        fin_sat[r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      row_cnt_q <= '0;
      for (int r = 0; r < NR; r++) begin
        acc_q[r] <= '0;
      end
    end else if (adv) begin
      s1_vld_q  <= q_pop_o && (q_ctrl_i.op == bsmv_pkg::FUNC_PRESET ||
                               q_ctrl_i.op == bsmv_pkg::FUNC_MAC);
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q && s3_row_end_q;
      out_vld_q <= s4_vld_q;
      row_cnt_q <= row_cnt_d;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_preset_q  <= (q_ctrl_i.op == bsmv_pkg::FUNC_PRESET);
      s1_row_end_q <= q_ctrl_i.row_end;
      s1_coef_q    <= q_coefs_i;
      s2_prod_q    <= prod;
      s2_preset_q  <= s1_preset_q;
      s2_row_end_q <= s1_row_end_q;
      s3_sum_q     <= sum;
      s3_preset_q  <= s2_preset_q;
      s3_row_end_q <= s2_row_end_q;
      s4_acc_q     <= acc_new;
      s4_row_q     <= row_cnt_q;
      out_sum_q    <= fin_val;
      out_row_q    <= s4_row_q;
      out_sat_q    <= |fin_sat;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sum0_o       = out_sum_q[0];
  assign sum1_o       = out_sum_q[1];
  assign sum2_o       = out_sum_q[2];
  assign row_number_o = out_row_q;
  assign saturated_o  = out_sat_q;

`ifndef SYNTHESIS
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s3_vld_q && s3_row_end_q) |=>
      (acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0))
    else $error("accumulators not cleared after row end");

  a_row_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s3_vld_q && s3_row_end_q) |=> (row_cnt_q == ROW_W'($past(row_cnt_q) + 1'b1)))
    else $error("row counter did not advance on emitted row");
`endif

endmodule

// ===== design/block_sparse_matvec_3x3.sv =====
// Top level of the block-sparse 3x3 matrix-vector multiply unit.
// Instantiates bsmv_front, bsmv_queue and bsmv_back; uses bsmv_pkg.
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o  | func_i column_i coef0_i..coef8_i row_end_i
//   out     | out_valid_o / out_stall_i| sum0_o sum1_o sum2_o row_number_o saturated_o
//
// One beat per cycle sustained while the output is not stalled. A row result
// passes queue pop with store read, multiply, block sum, accumulate and
// saturate before it reaches the outputs. The single store port and the nine
// multipliers each serve one item per cycle while the back pipeline advances.
// Reset clears accumulators, row counter and pipeline valids; the vector store
// is not cleared. A stalled output holds the back pipeline; the four-entry
// queue absorbs input beats until it fills, then in_stall_o rises.
module block_sparse_matvec_3x3 #(
  parameter int VECTOR_BLOCKS = bsmv_pkg::DEF_VECTOR_BLOCKS,
  parameter int VALUE_WIDTH   = bsmv_pkg::DEF_VALUE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        func_i,
  input  logic [bsmv_pkg::COL_W-1:0]        column_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef0_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef1_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef2_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef3_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef4_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef5_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef6_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef7_i,
  input  logic signed [VALUE_WIDTH-1:0]     coef8_i,
  input  logic                              row_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]     sum0_o,
  output logic signed [VALUE_WIDTH-1:0]     sum1_o,
  output logic signed [VALUE_WIDTH-1:0]     sum2_o,
  output logic [bsmv_pkg::ROW_W-1:0]        row_number_o,
  output logic                              saturated_o
);

  localparam int AW      = $clog2(VECTOR_BLOCKS);
  localparam int COEFS_W = bsmv_pkg::NUM_COEF * VALUE_WIDTH;
  localparam int CTRL_W  = $bits(bsmv_pkg::op_ctrl_t);
  localparam int ENT_W   = CTRL_W + AW + COEFS_W;

  logic [COEFS_W-1:0]  coefs;
  logic                push, pop, q_full, q_empty;
  bsmv_pkg::op_ctrl_t  ent_ctrl, head_ctrl;
  logic [AW-1:0]       ent_idx;
  logic [COEFS_W-1:0]  ent_coefs;
  logic [ENT_W-1:0]    q_wdata, q_rdata;
  logic [VALUE_WIDTH-1:0] sum0, sum1, sum2;

  assign coefs = {coef8_i, coef7_i, coef6_i, coef5_i, coef4_i,
                  coef3_i, coef2_i, coef1_i, coef0_i};

  bsmv_front #(
    .VECTOR_BLOCKS (VECTOR_BLOCKS),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .column_i    (column_i),
    .coefs_i     (coefs),
    .row_end_i   (row_end_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .ent_ctrl_o  (ent_ctrl),
    .ent_idx_o   (ent_idx),
    .ent_coefs_o (ent_coefs)
  );

  assign q_wdata = {ent_ctrl, ent_idx, ent_coefs};

  bsmv_queue #(
    .DEPTH (bsmv_pkg::QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign head_ctrl = bsmv_pkg::op_ctrl_t'(q_rdata[ENT_W-1 -: CTRL_W]);

  bsmv_back #(
    .VECTOR_BLOCKS (VECTOR_BLOCKS),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_ctrl_i     (head_ctrl),
    .q_idx_i      (q_rdata[COEFS_W +: AW]),
    .q_coefs_i    (q_rdata[COEFS_W-1:0]),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sum0_o       (sum0),
    .sum1_o       (sum1),
    .sum2_o       (sum2),
    .row_number_o (row_number_o),
    .saturated_o  (saturated_o)
  );

  assign sum0_o = sum0;
  assign sum1_o = sum1;
  assign sum2_o = sum2;

endmodule

// ===== bench/block_sparse_matvec_3x3_tb.sv =====
// Self-checking bench for block_sparse_matvec_3x3: loads x blocks, streams 3x3 matrix
// rows, and checks every row sum against an in-bench Q16.16 fixed-point predictor.
// Depends on bsmv_pkg and the block's top level only.
`timescale 1ns / 100ps

module block_sparse_matvec_3x3_tb;

  localparam int VW           = bsmv_pkg::DEF_VALUE_WIDTH;
  localparam int FRAC         = VW / 2;
  localparam int ACC_W        = 2 * VW + 8;
  localparam int BLOCKS       = bsmv_pkg::DEF_VECTOR_BLOCKS;
  localparam int ROWS_PER_LAP = 1 << bsmv_pkg::ROW_W;
  localparam int RANDOM_BEATS = 680;
  localparam int LONG_ROW     = 200;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int MAX_PRINTS   = 40;

  localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] ONE     = VW'(1) << FRAC;
  localparam logic signed [ACC_W-1:0] SUM_MAX = (ACC_W'(1) << (VW-1)) - 1;
  localparam logic signed [ACC_W-1:0] SUM_MIN = -(ACC_W'(1) << (VW-1));

  typedef logic [bsmv_pkg::NUM_COEF-1:0][VW-1:0] coef_blk_t;

  typedef struct packed {
    bsmv_pkg::func_e            op;
    logic [bsmv_pkg::COL_W-1:0] col;
    coef_blk_t                  coef;
    logic                       row_end;
    logic                       hold;     // wait for all row sums before sending
  } beat_t;

  typedef struct packed {
    logic [bsmv_pkg::NUM_ROWS-1:0][VW-1:0] sum;
    logic [bsmv_pkg::ROW_W-1:0]            row;
    logic                                  sat;
  } row_sum_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 func_d = bsmv_pkg::FUNC_NOP;
  logic [bsmv_pkg::COL_W-1:0] column_d = '0;
  coef_blk_t                  coef_d = '0;
  logic                       row_end_d = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [VW-1:0]              sum0_o, sum1_o, sum2_o;
  logic [bsmv_pkg::ROW_W-1:0] row_number_o;
  logic                       saturated_o;

  block_sparse_matvec_3x3 uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_d),
    .column_i     (column_d),
    .coef0_i      (coef_d[0]),
    .coef1_i      (coef_d[1]),
    .coef2_i      (coef_d[2]),
    .coef3_i      (coef_d[3]),
    .coef4_i      (coef_d[4]),
    .coef5_i      (coef_d[5]),
    .coef6_i      (coef_d[6]),
    .coef7_i      (coef_d[7]),
    .coef8_i      (coef_d[8]),
    .row_end_i    (row_end_d),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sum0_o       (sum0_o),
    .sum1_o       (sum1_o),
    .sum2_o       (sum2_o),
    .row_number_o (row_number_o),
    .saturated_o  (saturated_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  logic [bsmv_pkg::NUM_ROWS-1:0][VW-1:0] x_blocks [BLOCKS];
  logic signed [ACC_W-1:0]               row_acc [bsmv_pkg::NUM_ROWS];
  logic [bsmv_pkg::ROW_W-1:0]            next_row = '0;
  row_sum_t                              sums_due [$];

  beat_t beats_pending [$];
  int    loaded_cols [$];
  bit    col_loaded [BLOCKS];

  int errors = 0;
  int beats_sent = 0;
  int rows_checked = 0;
  int rows_clipped = 0;
  int row_laps = 0;
  int cycles = 0;

  function automatic logic signed [ACC_W-1:0] times(input logic [VW-1:0] a,
                                                    input logic [VW-1:0] b);
    logic signed [ACC_W-1:0] wa, wb;
    wa = $signed(a);
    wb = $signed(b);
    return wa * wb;
  endfunction

  // Drop the fraction toward minus infinity, then clip; top bit flags a clip.
  function automatic logic [VW:0] clip_sum(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] q;
    q = a >>> FRAC;
    if (q > SUM_MAX) return {1'b1, SUM_MAX[VW-1:0]};
    if (q < SUM_MIN) return {1'b1, SUM_MIN[VW-1:0]};
    return {1'b0, q[VW-1:0]};
  endfunction

  task automatic accumulate_beat(input beat_t b);
    logic signed [ACC_W-1:0] wz;
    logic [VW:0]             clipped;
    row_sum_t                r;
    int                      k;
    case (b.op)
      bsmv_pkg::FUNC_LOAD: x_blocks[b.col] = {b.coef[2], b.coef[1], b.coef[0]};
      bsmv_pkg::FUNC_PRESET: begin
        for (k = 0; k < bsmv_pkg::NUM_ROWS; k++) begin
          wz = $signed(b.coef[k]);
          row_acc[k] = wz <<< FRAC;
        end
      end
      bsmv_pkg::FUNC_MAC: begin
        for (k = 0; k < bsmv_pkg::NUM_ROWS; k++)
          row_acc[k] = row_acc[k] + times(b.coef[3*k], x_blocks[b.col][0])
                     + times(b.coef[3*k+1], x_blocks[b.col][1])
                     + times(b.coef[3*k+2], x_blocks[b.col][2]);
      end
      default: ;
    endcase
    if (b.row_end && (b.op == bsmv_pkg::FUNC_PRESET || b.op == bsmv_pkg::FUNC_MAC)) begin
      r.sat = 1'b0;
      for (k = 0; k < bsmv_pkg::NUM_ROWS; k++) begin
        clipped = clip_sum(row_acc[k]);
        r.sum[k] = clipped[VW-1:0];
        r.sat |= clipped[VW];
        row_acc[k] = '0;
      end
      r.row = next_row;
      next_row = next_row + 1'b1;
      sums_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic logic [VW-1:0] rand_value();
    int v;
    case ($urandom_range(0, 11))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3, 4, 5: return VW'($urandom);
      default: begin
        v = int'($urandom_range(0, 2097152)) - 1048576;
        return VW'(v);
      end
    endcase
  endfunction

  function automatic coef_blk_t rand_block();
    coef_blk_t k;
    for (int i = 0; i < bsmv_pkg::NUM_COEF; i++) k[i] = rand_value();
    return k;
  endfunction

  function automatic coef_blk_t fill_block(input logic [VW-1:0] v);
    coef_blk_t k;
    for (int i = 0; i < bsmv_pkg::NUM_COEF; i++) k[i] = v;
    return k;
  endfunction

  task automatic add_beat(input bsmv_pkg::func_e op, input int col, input coef_blk_t k,
                          input logic re, input logic hold = 1'b0);
    beat_t b;
    b.op = op;
    b.col = bsmv_pkg::COL_W'(col);
    b.coef = k;
    b.row_end = re;
    b.hold = hold;
    beats_pending.push_back(b);
    if (op == bsmv_pkg::FUNC_LOAD && !col_loaded[col]) begin
      col_loaded[col] = 1'b1;
      loaded_cols.push_back(col);
    end
  endtask

  function automatic int any_loaded_col();
    return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
  endfunction

  task automatic build_directed();
    coef_blk_t k;
    k = '0;
    k[0] = ONE; k[1] = ONE; k[2] = ONE;
    add_beat(bsmv_pkg::FUNC_LOAD, 0, k, 1'b1);       // row end on a load is ignored
    k[0] = VAL_MAX; k[1] = VAL_MIN; k[2] = '1;
    add_beat(bsmv_pkg::FUNC_LOAD, BLOCKS - 1, k, 1'b0);
    k[0] = ONE << 1; k[1] = -ONE; k[2] = ONE >> 1;
    add_beat(bsmv_pkg::FUNC_LOAD, 'h2AA, k, 1'b0);
    add_beat(bsmv_pkg::FUNC_LOAD, 'h155, fill_block(VAL_MIN), 1'b0);
    k = '0;
    k[0] = ONE; k[4] = ONE; k[8] = ONE;
    add_beat(bsmv_pkg::FUNC_MAC, 0, k, 1'b1);        // identity
    add_beat(bsmv_pkg::FUNC_MAC, BLOCKS - 1, fill_block(VAL_MAX), 1'b1);
    add_beat(bsmv_pkg::FUNC_MAC, BLOCKS - 1, fill_block(VAL_MIN), 1'b1);
    k = '0;
    k[0] = VAL_MAX; k[1] = VAL_MIN;
    add_beat(bsmv_pkg::FUNC_PRESET, 'h3FF, k, 1'b1); // preset with row end emits z
    add_beat(bsmv_pkg::FUNC_MAC, 'h2AA, rand_block(), 1'b0);
    k = '0;
    k[0] = ONE; k[1] = -ONE; k[2] = VW'(3);
    add_beat(bsmv_pkg::FUNC_PRESET, 0, k, 1'b0);     // preset mid-row drops prior sums
    add_beat(bsmv_pkg::FUNC_MAC, 0, fill_block(-ONE), 1'b1);
    add_beat(bsmv_pkg::FUNC_NOP, 'h155, rand_block(), 1'b1);
    add_beat(bsmv_pkg::FUNC_NOP, 'h2AA, rand_block(), 1'b0);
    // Fractions truncate toward minus infinity, on both signs.
    k = '0;
    k[2] = '1; k[5] = VW'(1); k[8] = '1;
    add_beat(bsmv_pkg::FUNC_MAC, 'h2AA, k, 1'b1, 1'b1);
    // Drive the accumulator past its wrap point in one long row.
    for (int i = 0; i < LONG_ROW; i++)
      add_beat(bsmv_pkg::FUNC_MAC, 'h155, fill_block(VAL_MIN), logic'(i == LONG_ROW - 1));
  endtask

  task automatic build_random();
    int n, macs;
    n = 0;
    while (n < RANDOM_BEATS) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          add_beat(bsmv_pkg::FUNC_LOAD, $urandom_range(0, BLOCKS - 1), rand_block(),
                   logic'($urandom_range(0, 1)));
          n++;
        end
        2: add_beat(bsmv_pkg::FUNC_NOP, $urandom_range(0, BLOCKS - 1), rand_block(),
                    logic'($urandom_range(0, 1)));
        3: begin
          // broken row: stray preset or block with no row end
          if ($urandom_range(0, 1))
            add_beat(bsmv_pkg::FUNC_PRESET, $urandom_range(0, BLOCKS - 1), rand_block(),
                     1'b0);
          else
            add_beat(bsmv_pkg::FUNC_MAC, any_loaded_col(), rand_block(), 1'b0);
          n++;
        end
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            add_beat(bsmv_pkg::FUNC_PRESET, $urandom_range(0, BLOCKS - 1), rand_block(),
                     1'b0);
            n++;
          end
          macs = $urandom_range(1, 4);
          for (int i = 0; i < macs; i++)
            add_beat(bsmv_pkg::FUNC_MAC, any_loaded_col(), rand_block(),
                     logic'(i == macs - 1));
          n += macs;
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- driver
  beat_t cur_beat;
  int    burst_left = 0;
  int    gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        accumulate_beat(cur_beat);
        beats_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(60, 150);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (beats_pending.size() > 0 &&
                     !(beats_pending[0].hold && sums_due.size() > 0)) begin
          cur_beat = beats_pending.pop_front();
          func_d <= cur_beat.op;
          column_d <= cur_beat.col;
          coef_d <= cur_beat.coef;
          row_end_d <= cur_beat.row_end;
          in_valid_i <= 1'b1;
          if (burst_left > 0) burst_left--;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int stall_mode = 0;
  int stall_span = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 200);
    end
    stall_span--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= logic'($urandom_range(0, 1));
      2: out_stall_i <= ($urandom_range(0, 7) == 0);
      default: begin
        if (stall_left == 0 && $urandom_range(0, 9) == 0)
          stall_left = $urandom_range(3, 16);
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    endcase
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(input string what, input int row,
                                 input logic [63:0] got, input logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch on row %0d, %s: got %h, want %h", row, what, got, want);
  endtask

  always @(posedge clk_i) begin
    row_sum_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        report_mismatch("unexpected beat", int'(row_number_o), {32'd0, sum0_o}, '0);
      end else begin
        want = sums_due.pop_front();
        if (sum0_o !== want.sum[0]) report_mismatch("sum0", want.row, sum0_o, want.sum[0]);
        if (sum1_o !== want.sum[1]) report_mismatch("sum1", want.row, sum1_o, want.sum[1]);
        if (sum2_o !== want.sum[2]) report_mismatch("sum2", want.row, sum2_o, want.sum[2]);
        if (row_number_o !== want.row)
          report_mismatch("row_number", want.row, row_number_o, want.row);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", want.row, saturated_o, want.sat);
        rows_checked++;
        if (want.sat) rows_clipped++;
        if (want.row == bsmv_pkg::ROW_W'(ROWS_PER_LAP - 1)) row_laps++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d row sums outstanding", cycles, sums_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    for (int k = 0; k < bsmv_pkg::NUM_ROWS; k++) row_acc[k] = '0;
    build_directed();
    build_random();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (beats_pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d beats accepted, %0d row sums checked, %0d of them clipped",
             beats_sent, rows_checked, rows_clipped);
    $display("row counter wrapped %0d time(s), %0d mismatches", row_laps, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
